### rtl/lsfx_pkg.sv
// ----------------------------------------------------------------------------
// lsfx_pkg
// Shared types, codes and helpers for the LSF to LPC expander.
// ----------------------------------------------------------------------------
package lsfx_pkg;

  localparam int unsigned PolyW    = 48;
  localparam int unsigned CosW     = 16;
  localparam int unsigned AngleW   = 16;
  localparam int unsigned OrderW   = 5;
  localparam int unsigned CoefW    = 32;
  localparam logic [OrderW-1:0] OrderReset = 5'd10;
  localparam logic signed [PolyW-1:0] OneQ15 = 48'sd32768;

  typedef enum logic [2:0] {
    CELL_HOLD,
    CELL_INIT,
    CELL_MUL,
    CELL_QUAD,
    CELL_SUB,
    CELL_ADD,
    CELL_SHIFT
  } cell_op_e;

  typedef struct packed {
    cell_op_e                 op;
    logic                     sel_asym;
    logic signed [CosW-1:0]   cos;
  } cell_ctl_t;

  typedef struct packed {
    logic signed [PolyW-1:0] s;
    logic signed [PolyW-1:0] a;
  } pair_t;

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_INIT,
    ST_FETCH,
    ST_MUL,
    ST_QUAD,
    ST_SUB,
    ST_ADD,
    ST_EMIT
  } state_e;

  function automatic logic signed [PolyW-1:0] sat48(input logic signed [51:0] v);
    logic signed [51:0] hi;
    logic signed [51:0] lo;
    hi = 52'sd140737488355327;
    lo = -52'sd140737488355328;
    if (v > hi) begin
      return hi[PolyW-1:0];
    end else if (v < lo) begin
      return lo[PolyW-1:0];
    end
    return v[PolyW-1:0];
  endfunction

endpackage

### rtl/lsfx_if.sv
// ----------------------------------------------------------------------------
// lsfx_if
// Valid/ready channels for angle beats in and coefficient beats out.
// ----------------------------------------------------------------------------
interface lsfx_in_if;
  logic        valid;
  logic        ready;
  logic [15:0] lsf_angle;
  modport source (output valid, output lsf_angle, input ready);
  modport sink   (input valid, input lsf_angle, output ready);
endinterface

interface lsfx_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] coef_value;
  logic [4:0]         coef_index;
  logic               last_coef;
  modport source (output valid, output coef_value, output coef_index, output last_coef,
                  input ready);
  modport sink   (input valid, input coef_value, input coef_index, input last_coef,
                  output ready);
endinterface

### rtl/lsf_to_lpc_expander.sv
// Angles arrive one beat at a time and are kept until lsf_order of them are
// in; the last one starts the expansion. Each quadratic factor goes through
// a table read, a multiply and an update across a row of MAX_ORDER+2 cells
// that all update at once, and the two linear factors follow; a vector yields
// order+1 output beats, one per cycle while the sink is ready. Angles are
// not taken during expansion and output; the next vector's first angle is
// taken while the final coefficient still waits. The cosine table is a
// registered ROM of COS_TABLE_DEPTH words.
// ----------------------------------------------------------------------------
// lsf_to_lpc_expander
// Line spectral frequencies to Q12 linear predictor coefficients.
// ----------------------------------------------------------------------------
module lsf_to_lpc_expander
  import lsfx_pkg::*;
#(
  parameter int unsigned MAX_ORDER       = 16,
  parameter int unsigned COS_TABLE_DEPTH = 1024
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              lsf_order_we_i,
  input  logic [OrderW-1:0] lsf_order_i,
  lsfx_in_if.sink           lsf_i,
  lsfx_out_if.source        coef_o
);

  localparam int unsigned PolyLen = MAX_ORDER + 2;
  localparam int unsigned LW      = $clog2(MAX_ORDER + 1);
  localparam int unsigned AW      = $clog2(MAX_ORDER);
  localparam int unsigned RW      = $clog2(COS_TABLE_DEPTH);

  logic [OrderW-1:0]  order_q;
  logic [LW-1:0]      ord_eff;
  logic [LW-1:0]      ord_q, ord_d;
  logic [LW-1:0]      cnt_q, cnt_d;
  logic [LW-1:0]      idx_q, idx_d;
  logic [AngleW-1:0]  angle_q [MAX_ORDER];
  state_e             state_q, state_d;
  cell_ctl_t          ctl;
  pair_t              cell_val [PolyLen];
  logic signed [CosW-1:0] cos_rd;
  logic [AngleW-1:0]  angle_rd;
  logic [RW-1:0]      rom_addr;
  logic               in_fire, load_out;

  logic               out_valid_q, out_valid_d;
  logic signed [CoefW-1:0] out_value_q;
  logic [OrderW-1:0]  out_index_q;
  logic               out_last_q;
  logic signed [49:0] sum;
  logic signed [49:0] shifted;
  logic signed [CoefW-1:0] coef_sat;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      order_q <= OrderReset;
    end else if (lsf_order_we_i) begin
      order_q <= lsf_order_i;
    end
  end

  always_comb begin
    if (order_q == '0) begin
      ord_eff = LW'(1);
    end else if (32'(order_q) > MAX_ORDER) begin
      ord_eff = LW'(MAX_ORDER);
    end else begin
      ord_eff = LW'(order_q);
    end
  end

  assign lsf_i.ready = (state_q == ST_LOAD);
  assign in_fire     = lsf_i.valid && lsf_i.ready;

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      angle_q[cnt_q[AW-1:0]] <= lsf_i.lsf_angle;
    end
  end

  assign angle_rd = angle_q[idx_q[AW-1:0]];
  assign rom_addr = RW'((32'(angle_rd) * COS_TABLE_DEPTH) >> 16);

  lsfx_cos_rom #(.COS_TABLE_DEPTH(COS_TABLE_DEPTH)) u_rom (
    .clk_i  (clk_i),
    .addr_i (rom_addr),
    .data_o (cos_rd)
  );

  always_comb begin
    state_d      = state_q;
    cnt_d        = cnt_q;
    idx_d        = idx_q;
    ord_d        = ord_q;
    ctl.op       = CELL_HOLD;
    ctl.sel_asym = idx_q[0];
    ctl.cos      = cos_rd;
    load_out     = 1'b0;
    case (state_q)
      ST_LOAD: begin
        if (in_fire) begin
          if (cnt_q + LW'(1) >= ord_eff) begin
            cnt_d   = '0;
            ord_d   = ord_eff;
            state_d = ST_INIT;
          end else begin
            cnt_d = cnt_q + LW'(1);
          end
        end
      end
      ST_INIT: begin
        ctl.op  = CELL_INIT;
        idx_d   = '0;
        state_d = ST_FETCH;
      end
      ST_FETCH: state_d = ST_MUL;
      ST_MUL: begin
        ctl.op  = CELL_MUL;
        state_d = ST_QUAD;
      end
      ST_QUAD: begin
        ctl.op = CELL_QUAD;
        if (idx_q + LW'(1) >= ord_q) begin
          state_d = ST_SUB;
        end else begin
          idx_d   = idx_q + LW'(1);
          state_d = ST_FETCH;
        end
      end
      ST_SUB: begin
        ctl.op       = CELL_SUB;
        ctl.sel_asym = 1'b1;
        state_d      = ST_ADD;
      end
      ST_ADD: begin
        ctl.op       = CELL_ADD;
        ctl.sel_asym = ord_q[0];
        idx_d        = '0;
        state_d      = ST_EMIT;
      end
      ST_EMIT: begin
        if (!out_valid_q || coef_o.ready) begin
          load_out = 1'b1;
          ctl.op   = CELL_SHIFT;
          if (idx_q == ord_q) begin
            state_d = ST_LOAD;
          end else begin
            idx_d = idx_q + LW'(1);
          end
        end
      end
      default: state_d = ST_LOAD;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_LOAD;
      cnt_q   <= '0;
      idx_q   <= '0;
      ord_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      idx_q   <= idx_d;
      ord_q   <= ord_d;
    end
  end

  for (genvar k = 0; k < PolyLen; k++) begin : g_cell
    pair_t p1, p2, nx;
    assign p1 = (k >= 1) ? cell_val[(k >= 1) ? k - 1 : 0] : '0;
    assign p2 = (k >= 2) ? cell_val[(k >= 2) ? k - 2 : 0] : '0;
    assign nx = (k + 1 < PolyLen) ? cell_val[(k + 1 < PolyLen) ? k + 1 : k] : '0;
    lsfx_cell #(.IS_HEAD(k == 0)) u_cell (
      .clk_i   (clk_i),
      .ctl_i   (ctl),
      .prev1_i (p1),
      .prev2_i (p2),
      .next_i  (nx),
      .val_o   (cell_val[k])
    );
  end

  always_comb begin
    sum     = 50'(cell_val[0].s) + 50'(cell_val[0].a) + 50'sd8;
    shifted = sum >>> 4;
    if (shifted > 50'sd2147483647) begin
      coef_sat = 32'sh7fffffff;
    end else if (shifted < -50'sd2147483648) begin
      coef_sat = 32'sh80000000;
    end else begin
      coef_sat = shifted[CoefW-1:0];
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (load_out) begin
      out_valid_d = 1'b1;
    end else if (coef_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      out_value_q <= coef_sat;
      out_index_q <= OrderW'(idx_q);
      out_last_q  <= (idx_q == ord_q);
    end
  end

  assign coef_o.valid      = out_valid_q;
  assign coef_o.coef_value = out_value_q;
  assign coef_o.coef_index = out_index_q;
  assign coef_o.last_coef  = out_last_q;

endmodule

### rtl/lsfx_cos_rom.sv
// ----------------------------------------------------------------------------
// lsfx_cos_rom
// Q15 cosine table over half a turn, built at elaboration, registered read.
// ----------------------------------------------------------------------------
module lsfx_cos_rom
  import lsfx_pkg::*;
#(
  parameter int unsigned COS_TABLE_DEPTH = 1024
) (
  input  logic                                 clk_i,
  input  logic [$clog2(COS_TABLE_DEPTH)-1:0]   addr_i,
  output logic signed [CosW-1:0]               data_o
);

  typedef logic signed [CosW-1:0] rom_t [COS_TABLE_DEPTH];

  // Shift-and-subtract quotient, used only while building the table.
  function automatic longint unsigned div_u64(input longint unsigned n,
                                              input longint unsigned d);
    longint unsigned q;
    longint unsigned r;
    q = '0;
    r = '0;
    for (int b = 63; b >= 0; b--) begin
      r = {r[62:0], n[b]};
      if (r >= d) begin
        r    = r - d;
        q[b] = 1'b1;
      end
    end
    return q;
  endfunction

  function automatic rom_t build_rom();
    rom_t              r;
    longint unsigned   x;
    longint unsigned   x2;
    longint unsigned   t;
    longint unsigned   q;
    longint unsigned   rr;
    longint unsigned   j;
    logic              neg;
    for (int i = 0; i < COS_TABLE_DEPTH; i++) begin
      j   = longint'(i);
      neg = 1'b0;
      if (2 * j > COS_TABLE_DEPTH) begin
        j   = COS_TABLE_DEPTH - j;
        neg = 1'b1;
      end
      x  = div_u64(j * 64'd3373259426 + (64'(COS_TABLE_DEPTH) >> 1),
                   64'(COS_TABLE_DEPTH));
      x2 = (x * x) >> 30;
      t  = 64'd1 << 30;
      for (int k = 12; k >= 1; k--) begin
        q = div_u64((x2 * t) >> 30, 64'((2 * k - 1) * (2 * k)));
        t = (q > (64'd1 << 30)) ? 64'd0 : (64'd1 << 30) - q;
      end
      rr = (t + (64'd1 << 14)) >> 15;
      if (rr > 64'd32767) rr = 64'd32767;
      r[i] = neg ? -$signed(rr[CosW-1:0]) : $signed(rr[CosW-1:0]);
    end
    return r;
  endfunction

  localparam rom_t CosRom = build_rom();

  logic signed [CosW-1:0] data_q;

  always_ff @(posedge clk_i) begin
    data_q <= CosRom[addr_i];
  end

  assign data_o = data_q;

endmodule

### rtl/lsfx_cell.sv
// ----------------------------------------------------------------------------
// lsfx_cell
// One coefficient slot of both polynomials; updates from its lower neighbours, shifts from its upper one.
// ----------------------------------------------------------------------------
module lsfx_cell
  import lsfx_pkg::*;
#(
  parameter bit IS_HEAD = 1'b0
) (
  input  logic      clk_i,
  input  cell_ctl_t ctl_i,
  input  pair_t     prev1_i,
  input  pair_t     prev2_i,
  input  pair_t     next_i,
  output pair_t     val_o
);

  pair_t                    val_q, val_d;
  logic signed [49:0]       prod_q, prod_d;
  logic signed [PolyW-1:0]  own, p1, p2, upd;
  logic signed [63:0]       full;
  logic signed [51:0]       acc;

  always_comb begin
    own  = ctl_i.sel_asym ? val_q.a : val_q.s;
    p1   = ctl_i.sel_asym ? prev1_i.a : prev1_i.s;
    p2   = ctl_i.sel_asym ? prev2_i.a : prev2_i.s;
    full = 64'(ctl_i.cos) * 64'(p1) + 64'sd8192;
    prod_d = prod_q;
    val_d  = val_q;
    acc    = 52'(own);
    case (ctl_i.op)
      CELL_QUAD: acc = 52'(own) - 52'(prod_q) + 52'(p2);
      CELL_SUB:  acc = 52'(own) - 52'(p1);
      CELL_ADD:  acc = 52'(own) + 52'(p1);
      default:   acc = 52'(own);
    endcase
    upd = sat48(acc);
    case (ctl_i.op)
      CELL_INIT: begin
        val_d.s = IS_HEAD ? OneQ15 : '0;
        val_d.a = IS_HEAD ? OneQ15 : '0;
      end
      CELL_MUL:  prod_d = full[63:14];
      CELL_QUAD, CELL_SUB, CELL_ADD: begin
        if (ctl_i.sel_asym) val_d.a = upd;
        else                val_d.s = upd;
      end
      CELL_SHIFT: val_d = next_i;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    val_q  <= val_d;
    prod_q <= prod_d;
  end

  assign val_o = val_q;

endmodule

### rtl/lsfx_checker.sv
// ----------------------------------------------------------------------------
// lsfx_checker
// Port-level checks on the expander's coefficient stream.
// ----------------------------------------------------------------------------
module lsfx_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_ready_i,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic [31:0] out_value_i,
  input logic [4:0]  out_index_i,
  input logic        out_last_i
);

  a_no_beat_in_reset: assert property (@(posedge clk_i) !rst_ni |-> !out_valid_i)
    else $error("beat offered during reset");

  a_head_is_one: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_index_i == 5'd0 |-> out_value_i == 32'd4096)
    else $error("leading coefficient not unity");

  a_last_not_head: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_last_i |-> out_index_i != 5'd0)
    else $error("vector ended at index zero");

  a_index_steps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_ready_i && !out_last_i |=>
      out_valid_i && out_index_i == $past(out_index_i) + 5'd1)
    else $error("coefficient index skipped");

  a_no_input_mid_vector: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_last_i |-> !in_ready_i)
    else $error("angle taken while vector incomplete");

endmodule

bind lsf_to_lpc_expander lsfx_checker u_lsfx_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_ready_i  (lsf_i.ready),
  .out_valid_i (coef_o.valid),
  .out_ready_i (coef_o.ready),
  .out_value_i (coef_o.coef_value),
  .out_index_i (coef_o.coef_index),
  .out_last_i  (coef_o.last_coef)
);

### verif/lsf_to_lpc_expander_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lsf_to_lpc_expander_test
// Streams LSF angle beats through the expander under random bursts and
// output stalls, predicts every coefficient beat with an independent
// fixed-point expansion and checks each one in order.
// ----------------------------------------------------------------------------
module lsf_to_lpc_expander_test;
  import lsfx_pkg::*;

  localparam int          NumLsf    = 16;
  localparam int          PolyLen   = NumLsf + 2;
  localparam int          CosDepth  = 1024;
  localparam int          ExpandLat = 3 * NumLsf + 3 + 24;
  localparam int          IdleLimit = 6000;
  localparam int          LongHold  = 400;
  localparam longint      Max48     = (64'sd1 <<< 47) - 1;
  localparam longint      Min48     = -(64'sd1 <<< 47);
  localparam longint unsigned OneQ30 = 64'd1 << 30;
  localparam longint unsigned PiQ30  = 64'd3373259426;

  typedef struct {
    logic signed [CoefW-1:0]  value;
    logic [OrderW-1:0]        index;
    logic                     last;
  } coef_t;

  logic clk_i;
  logic rst_ni;
  logic lsf_order_we_i;
  logic [OrderW-1:0] lsf_order_i;

  lsfx_in_if  angle_ch ();
  lsfx_out_if coef_ch ();

  lsf_to_lpc_expander dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .lsf_order_we_i (lsf_order_we_i),
    .lsf_order_i    (lsf_order_i),
    .lsf_i          (angle_ch),
    .coef_o         (coef_ch)
  );

  coef_t coef_queue[$];
  logic [OrderW-1:0] order_reg;
  logic [AngleW-1:0] angle_mem[NumLsf];
  int unsigned       load_cnt;
  int                errors;
  int                hold_cnt;
  int                stall_pct;
  int                burst_left;
  int                angles_sent;

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  function automatic longint cos_q15(int unsigned i);
    longint unsigned j, x, x2, t, q, r;
    bit neg;
    j = i;
    neg = 1'b0;
    if (2 * j > CosDepth) begin
      j = CosDepth - j;
      neg = 1'b1;
    end
    x  = (j * PiQ30 + CosDepth / 2) / CosDepth;
    x2 = (x * x) >> 30;
    t  = OneQ30;
    for (int k = 12; k >= 1; k--) begin
      q = ((x2 * t) >> 30) / longint'((2 * k - 1) * (2 * k));
      t = (q > OneQ30) ? 64'd0 : OneQ30 - q;
    end
    r = (t + (64'd1 << 14)) >> 15;
    if (r > 32767) r = 32767;
    return neg ? -longint'(r) : longint'(r);
  endfunction

  function automatic longint clip48(longint v);
    if (v > Max48) return Max48;
    if (v < Min48) return Min48;
    return v;
  endfunction

  // Store one angle; on the vector's last angle expand and queue coefficients.
  task automatic take_angle(logic [AngleW-1:0] angle);
    int unsigned ord;
    longint sp[PolyLen];
    longint ap[PolyLen];
    longint c, v;
    coef_t e;
    ord = order_reg;
    if (ord < 1) ord = 1;
    if (ord > NumLsf) ord = NumLsf;
    if (load_cnt >= NumLsf) load_cnt = 0;
    angle_mem[load_cnt] = angle;
    load_cnt++;
    if (load_cnt < ord) return;
    load_cnt = 0;
    for (int k = 0; k < PolyLen; k++) begin
      sp[k] = 0;
      ap[k] = 0;
    end
    sp[0] = 32768;
    ap[0] = 32768;
    for (int i = 0; i < ord; i++) begin
      c = cos_q15(angle_mem[i] >> 6);
      for (int k = PolyLen - 1; k >= 0; k--) begin
        if (i % 2 == 0) begin
          v = sp[k];
          if (k >= 1) v -= (c * sp[k-1] + 64'sd8192) >>> 14;
          if (k >= 2) v += sp[k-2];
          sp[k] = clip48(v);
        end else begin
          v = ap[k];
          if (k >= 1) v -= (c * ap[k-1] + 64'sd8192) >>> 14;
          if (k >= 2) v += ap[k-2];
          ap[k] = clip48(v);
        end
      end
    end
    for (int k = PolyLen - 1; k >= 1; k--) ap[k] = clip48(ap[k] - ap[k-1]);
    for (int k = PolyLen - 1; k >= 1; k--) begin
      if (ord % 2 == 1) ap[k] = clip48(ap[k] + ap[k-1]);
      else sp[k] = clip48(sp[k] + sp[k-1]);
    end
    for (int k = 0; k <= ord; k++) begin
      v = (sp[k] + ap[k] + 64'sd8) >>> 4;
      if (v > 64'sd2147483647) v = 64'sd2147483647;
      if (v < -64'sd2147483648) v = -64'sd2147483648;
      e.value = v[CoefW-1:0];
      e.index = k[OrderW-1:0];
      e.last  = (k == ord);
      coef_queue.push_back(e);
    end
  endtask

  // One angle beat; the sender may idle between bursts of random length.
  task automatic send_angle(logic [AngleW-1:0] angle);
    if (burst_left == 0) begin
      int gap;
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      burst_left = $urandom_range(1, 12);
      repeat (gap) begin
        @(negedge clk_i);
        angle_ch.valid <= 1'b0;
        angle_ch.lsf_angle <= AngleW'($urandom);
      end
    end
    burst_left--;
    @(negedge clk_i);
    angle_ch.valid <= 1'b1;
    angle_ch.lsf_angle <= angle;
    do @(posedge clk_i); while (!angle_ch.ready);
    take_angle(angle);
    angles_sent++;
  endtask

  task automatic drain_idle();
    @(negedge clk_i);
    angle_ch.valid <= 1'b0;
    wait (coef_queue.size() == 0);
    repeat (ExpandLat) @(posedge clk_i);
  endtask

  task automatic write_order(logic [OrderW-1:0] val);
    drain_idle();
    @(negedge clk_i);
    lsf_order_we_i <= 1'b1;
    lsf_order_i <= val;
    @(negedge clk_i);
    lsf_order_we_i <= 1'b0;
    order_reg = val;
  endtask

  task automatic send_vector(int n);
    repeat (n) send_angle(AngleW'($urandom));
  endtask

  task automatic test_reset_order();
    send_angle(16'h0000);
    send_angle(16'hFFFF);
    send_angle(16'h8000);
    send_angle(16'h7FFF);
    send_angle(16'h0040);
    send_angle(16'hFFC0);
    send_angle(16'h4000);
    send_angle(16'hC000);
    send_angle(16'h0000);
    send_angle(16'h0000);
  endtask

  task automatic test_order_bounds();
    write_order(5'd0);
    send_angle(16'h0000);
    send_angle(16'hFFFF);
    write_order(5'd31);
    for (int i = 0; i < NumLsf; i++) send_angle(16'(i * 4096));
    write_order(5'd17);
    send_vector(NumLsf);
    write_order(5'd1);
    send_angle(16'h8000);
  endtask

  task automatic test_order_change_mid_vector();
    write_order(5'd10);
    send_vector(3);
    write_order(5'd2);
    send_angle(16'h1234);
    write_order(5'd6);
    send_vector(4);
    write_order(5'd5);
    send_angle(16'hABCD);
  endtask

  task automatic test_backpressure();
    write_order(5'd4);
    @(posedge clk_i);
    hold_cnt = LongHold;
    send_vector(12);
  endtask

  task automatic test_random();
    logic [OrderW-1:0] ord;
    while (angles_sent < 230) begin
      case ($urandom_range(0, 9))
        0:       ord = OrderW'($urandom_range(17, 31));
        1:       ord = 5'd0;
        2:       ord = 5'd16;
        default: ord = OrderW'($urandom_range(1, 16));
      endcase
      stall_pct = $urandom_range(0, 2) * 30;
      write_order(ord);
      repeat ($urandom_range(1, 4)) send_vector((ord == 0) ? 1 : (ord > 16 ? 16 : ord));
    end
  endtask

  // Receiver: its own stall pattern plus an optional long hold-off.
  initial begin
    coef_ch.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_cnt > 0) begin
        hold_cnt--;
        coef_ch.ready <= 1'b0;
      end else begin
        coef_ch.ready <= ($urandom_range(0, 99) >= stall_pct);
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && coef_ch.valid && coef_ch.ready) begin
      if (coef_queue.size() == 0) begin
        $error("unexpected coefficient beat, index %0d", coef_ch.coef_index);
        errors++;
      end else begin
        coef_t e;
        e = coef_queue.pop_front();
        if (coef_ch.coef_value !== e.value) begin
          $error("coef_value: expected %0d, got %0d", e.value, coef_ch.coef_value);
          errors++;
        end
        if (coef_ch.coef_index !== e.index) begin
          $error("coef_index: expected %0d, got %0d", e.index, coef_ch.coef_index);
          errors++;
        end
        if (coef_ch.last_coef !== e.last) begin
          $error("last_coef: expected %0d, got %0d", e.last, coef_ch.last_coef);
          errors++;
        end
      end
    end
  end

  initial begin
    int idle;
    idle = 0;
    forever begin
      @(posedge clk_i);
      if ((angle_ch.valid && angle_ch.ready) || (coef_ch.valid && coef_ch.ready)) idle = 0;
      else idle++;
      if (idle > IdleLimit) begin
        $display("lsf_to_lpc_expander_test: errors");
        $finish;
      end
    end
  end

  initial begin
    errors = 0;
    hold_cnt = 0;
    stall_pct = 30;
    burst_left = 0;
    angles_sent = 0;
    load_cnt = 0;
    order_reg = OrderReset;
    rst_ni = 1'b0;
    lsf_order_we_i = 1'b0;
    lsf_order_i = '0;
    angle_ch.valid = 1'b0;
    angle_ch.lsf_angle = '0;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    repeat (ExpandLat) @(posedge clk_i);

    test_reset_order();
    test_order_bounds();
    test_order_change_mid_vector();
    test_backpressure();
    test_random();

    drain_idle();
    if (errors == 0) begin
      $display("lsf_to_lpc_expander_test: clean");
    end else begin
      $display("lsf_to_lpc_expander_test: errors");
    end
    $finish;
  end

endmodule
